[src/dust_sensor_frame_parser_defines.svh]
// ----------------------------------------------------------------------------
// Dust sensor frame parser assertion macros
// Concurrent assertion helpers shared by the parser RTL. Defining ASSERT_OFF
// removes every check.
// ----------------------------------------------------------------------------
`ifndef DUST_SENSOR_FRAME_PARSER_DEFINES_SVH
`define DUST_SENSOR_FRAME_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define DSFP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DSFP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define DSFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[src/dsfp_pkg.sv]
// ----------------------------------------------------------------------------
// Dust sensor frame parser package
// Beat types, protocol constants and configuration codes of the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsfp_pkg;

    // Buffer and queue sizing defaults.
    localparam int BUFFER_BYTES_DEFAULT = 64;
    localparam int CMD_QUEUE_DEPTH      = 4;
    localparam int RES_QUEUE_DEPTH      = 2;

    // Input request codes.
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Configuration register indexes.
    localparam int   CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMALDEHYDE_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS         = 1'b1;
    localparam int   CFG_DATA_W = 8;
    localparam logic [7:0] GAP_TICKS_RESET = 8'd10;

    // Frame layout.
    localparam logic [7:0] HEADER_BYTE0     = 8'h42;
    localparam logic [7:0] HEADER_BYTE1     = 8'h4d;
    localparam int         LEN_NORMAL       = 32;
    localparam int         LEN_FORMALDEHYDE = 40;
    localparam int         VALS_NORMAL      = 13;
    localparam int         VALS_FORMALDEHYDE = 18;
    localparam int         FIRST_VALUE_POS  = 4;
    localparam int         BYTE_VALUE_POS   = 36;
    localparam int         BYTE_INDEX_OFFSET = 20;

    // Frame status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_HEADER   = 2'd1,
        ST_CHECKSUM = 2'd2,
        ST_LENGTH   = 2'd3
    } t_status;

    // Input beat.
    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_item;

    // Result beat.
    typedef struct packed {
        logic [1:0]  frame_status;
        logic [4:0]  value_index;
        logic [15:0] value_word;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

[src/dsfp_queue.sv]
// ----------------------------------------------------------------------------
// Dust sensor frame parser queue
// Small register queue with full and empty flags, used between the stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsfp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic      [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [NW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    // Flags and handshakes.
    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[src/dsfp_front.sv]
// ----------------------------------------------------------------------------
// Dust sensor frame parser front end
// Accepts input beats, tracks fill and idle counts and issues store and
// close commands to the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsfp_front #(
    parameter int BUFFER_BYTES = dsfp_pkg::BUFFER_BYTES_DEFAULT,
    parameter int CW           = $clog2(BUFFER_BYTES + 1),
    parameter int CMD_W        = 1 + 8 + CW
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire dsfp_pkg::t_item      i_item,
    output logic                      o_full,
    input  wire logic [7:0]           i_gap_ticks,
    input  wire logic                 i_cmd_full,
    output logic                      o_cmd_push,
    output logic      [CMD_W-1:0]     o_cmd
);

    import dsfp_pkg::*;

    logic [CW-1:0] r_byte_count;
    logic [7:0]    r_idle_count;
    logic          accept;
    logic          room;
    logic [8:0]    idle_next;
    logic          do_close;
    logic          do_store;

    // Classify the accepted beat.
    always_comb begin
        accept    = i_push && !i_cmd_full;
        room      = (r_byte_count < CW'(BUFFER_BYTES));
        idle_next = {1'b0, r_idle_count} + 9'd1;
        do_store  = accept && (i_item.req_type == REQ_BYTE) && room;
        do_close  = accept && (i_item.req_type == REQ_TICK) && (r_byte_count != '0)
                    && (idle_next > {1'b0, i_gap_ticks});
    end

    assign o_full     = i_cmd_full;
    assign o_cmd_push = do_store || do_close;
    assign o_cmd      = {do_close, i_item.rx_byte, r_byte_count};

    // Fill and idle counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_idle_count <= '0;
        end else if (do_store) begin
            r_byte_count <= r_byte_count + 1'b1;
            r_idle_count <= '0;
        end else if (do_close) begin
            r_byte_count <= '0;
            r_idle_count <= '0;
        end else if (accept && (i_item.req_type == REQ_TICK) && (r_byte_count != '0)) begin
            r_idle_count <= idle_next[7:0];
        end
    end

endmodule

`default_nettype wire

[src/dsfp_back.sv]
// ----------------------------------------------------------------------------
// Dust sensor frame parser back end
// Owns the frame buffer, stores bytes, and on a close walks the frame to
// check header, checksum and length before emitting results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsfp_back #(
    parameter int BUFFER_BYTES = dsfp_pkg::BUFFER_BYTES_DEFAULT,
    parameter int CW           = $clog2(BUFFER_BYTES + 1),
    parameter int CMD_W        = 1 + 8 + CW
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_empty,
    input  wire logic [CMD_W-1:0]   i_cmd,
    output logic                    o_cmd_pop,
    input  wire logic               i_mode,
    input  wire logic               i_res_full,
    output logic                    o_res_push,
    output dsfp_pkg::t_result       o_res
);

    import dsfp_pkg::*;

    localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_CHECK,
        S_EMIT_RD,
        S_EMIT_USE
    } t_state;

    t_state        r_state;
    logic [7:0]    r_mem [BUFFER_BYTES];
    logic [7:0]    r_rdata;
    logic [CW-1:0] r_addr;
    logic [CW-1:0] r_dpos;
    logic          r_dv;
    logic [CW-1:0] r_cnt;
    logic [15:0]   r_sum;
    logic [15:0]   r_chk;
    logic          r_hdr_ok;
    logic          r_short;
    logic [7:0]    r_hi;

    logic          cmd_close;
    logic [7:0]    cmd_data;
    logic [CW-1:0] cmd_pos;
    logic          mem_we;
    t_status       check_status;
    logic [CW-1:0] want_len;
    logic [4:0]    last_idx;
    logic          is_word;
    logic          is_hi;
    logic [4:0]    val_idx;
    logic [15:0]   val_word;

    // Command fields and frame checks.
    always_comb begin
        cmd_close = i_cmd[CMD_W-1];
        cmd_data  = i_cmd[CW+7:CW];
        cmd_pos   = i_cmd[CW-1:0];
        o_cmd_pop = (r_state == S_IDLE) && !i_cmd_empty;
        mem_we    = o_cmd_pop && !cmd_close;
        want_len  = i_mode ? CW'(LEN_FORMALDEHYDE) : CW'(LEN_NORMAL);
        last_idx  = i_mode ? 5'(VALS_FORMALDEHYDE - 1) : 5'(VALS_NORMAL - 1);
        if (r_short || !r_hdr_ok) begin
            check_status = ST_HEADER;
        end else if (r_sum != r_chk) begin
            check_status = ST_CHECKSUM;
        end else if (r_cnt != want_len) begin
            check_status = ST_LENGTH;
        end else begin
            check_status = ST_OK;
        end
    end

    // Measurement value at the current read position.
    always_comb begin
        is_word = (r_addr < CW'(BYTE_VALUE_POS));
        is_hi   = is_word && !r_addr[0];
        if (is_word) begin
            val_idx  = 5'((r_addr - CW'(FIRST_VALUE_POS)) >> 1);
            val_word = {r_hi, r_rdata};
        end else begin
            val_idx  = 5'(r_addr - CW'(BYTE_INDEX_OFFSET));
            val_word = {8'h00, r_rdata};
        end
    end

    // Result beat.
    always_comb begin
        o_res_push = 1'b0;
        o_res      = '0;
        if (r_state == S_CHECK && check_status != ST_OK) begin
            o_res_push         = !i_res_full;
            o_res.frame_status = check_status;
            o_res.last         = 1'b1;
        end else if (r_state == S_EMIT_USE && !is_hi) begin
            o_res_push         = !i_res_full;
            o_res.frame_status = ST_OK;
            o_res.value_index  = val_idx;
            o_res.value_word   = val_word;
            o_res.last         = (val_idx == last_idx);
        end
    end

    // Frame buffer with registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[cmd_pos[AW-1:0]] <= cmd_data;
        end
        r_rdata <= r_mem[r_addr[AW-1:0]];
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dv    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop && cmd_close) begin
                        r_cnt    <= cmd_pos;
                        r_addr   <= '0;
                        r_dv     <= 1'b0;
                        r_sum    <= '0;
                        r_chk    <= '0;
                        r_hdr_ok <= 1'b1;
                        if (cmd_pos < CW'(2)) begin
                            r_short <= 1'b1;
                            r_state <= S_CHECK;
                        end else begin
                            r_short <= 1'b0;
                            r_state <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    // Reads run one address ahead of the data being summed.
                    if (r_addr < r_cnt) begin
                        r_addr <= r_addr + 1'b1;
                        r_dpos <= r_addr;
                        r_dv   <= 1'b1;
                    end else begin
                        r_dv   <= 1'b0;
                    end
                    if (r_dv) begin
                        if (r_dpos == CW'(0)) begin
                            r_hdr_ok <= r_hdr_ok && (r_rdata == HEADER_BYTE0);
                        end else if (r_dpos == CW'(1)) begin
                            r_hdr_ok <= r_hdr_ok && (r_rdata == HEADER_BYTE1);
                        end
                        if (r_dpos < r_cnt - CW'(2)) begin
                            r_sum <= r_sum + {8'h00, r_rdata};
                        end
                        if (r_dpos == r_cnt - CW'(2)) begin
                            r_chk[15:8] <= r_rdata;
                        end
                        if (r_dpos == r_cnt - CW'(1)) begin
                            r_chk[7:0] <= r_rdata;
                            r_dv       <= 1'b0;
                            r_state    <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (check_status == ST_OK) begin
                        r_addr  <= CW'(FIRST_VALUE_POS);
                        r_state <= S_EMIT_RD;
                    end else if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_USE;
                end
                S_EMIT_USE: begin
                    if (is_hi) begin
                        r_hi    <= r_rdata;
                        r_addr  <= r_addr + 1'b1;
                        r_state <= S_EMIT_RD;
                    end else if (!i_res_full) begin
                        if (val_idx == last_idx) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_addr  <= r_addr + 1'b1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[src/dust_sensor_frame_parser.sv]
// ----------------------------------------------------------------------------
// Dust sensor frame parser
// Byte and tick beats are taken one per cycle while the command queue has room;
// a byte is written into the buffer by the back end in the same cycle that it leaves that queue.
// A closing tick starts a walk of the buffer that sums the frame and checks it;
// the values are then read byte by byte from the single buffer read port,
// and each value goes out as one result beat; an error status follows
// the walk directly. Synchronous active-low reset empties both queues and
// clears the counters; the frame buffer is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "dust_sensor_frame_parser_defines.svh"

module dust_sensor_frame_parser #(
    parameter int BUFFER_BYTES = dsfp_pkg::BUFFER_BYTES_DEFAULT,
    parameter int CMD_DEPTH    = dsfp_pkg::CMD_QUEUE_DEPTH,
    parameter int RES_DEPTH    = dsfp_pkg::RES_QUEUE_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               push,
    input  wire dsfp_pkg::t_item                    i_item,
    output logic                                    full,
    output logic                                    empty,
    input  wire logic                               pop,
    output dsfp_pkg::t_result                       o_result,
    input  wire logic                               i_cfg_we,
    input  wire logic [dsfp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [dsfp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import dsfp_pkg::*;

    localparam int CW    = $clog2(BUFFER_BYTES + 1);
    localparam int CMD_W = 1 + 8 + CW;
    localparam int RES_W = $bits(t_result);

    logic             r_mode;
    logic [7:0]       r_gap_ticks;
    logic             cmd_push;
    logic [CMD_W-1:0] cmd_in;
    logic             cmd_full;
    logic             cmd_pop;
    logic             cmd_empty;
    logic [CMD_W-1:0] cmd_out;
    logic             res_push;
    t_result          res_in;
    logic             res_full;
    logic [RES_W-1:0] res_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_gap_ticks <= GAP_TICKS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FORMALDEHYDE_MODE: r_mode      <= i_cfg_data[0];
                CFG_GAP_TICKS:         r_gap_ticks <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: classification and counters.
    dsfp_front #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .CW           (CW),
        .CMD_W        (CMD_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_gap_ticks (r_gap_ticks),
        .i_cmd_full  (cmd_full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    // Command queue between front and back.
    dsfp_queue #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (cmd_out)
    );

    // Back end: buffer, checks and value walk.
    dsfp_back #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .CW           (CW),
        .CMD_W        (CMD_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_mode      (r_mode),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // Result queue toward the consumer.
    dsfp_queue #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out)
    );

    assign o_result = t_result'(res_out);

    // Checks on the internal handshakes.
    `DSFP_ASSERT_IMPL(a_res_push_room, i_clk, i_rst_n, res_push, !res_full,
        "result beat pushed into a full result queue")
    `DSFP_ASSERT_IMPL(a_cmd_from_accept, i_clk, i_rst_n, cmd_push, push && !full,
        "command issued without an accepted input beat")
    `DSFP_ASSERT_IMPL(a_error_beat_form, i_clk, i_rst_n,
        res_push && (res_in.frame_status != ST_OK),
        res_in.last && (res_in.value_index == 5'd0) && (res_in.value_word == 16'd0),
        "error beat must be a single final beat with zero payload")
    `DSFP_ASSERT_NEXT(a_close_busy, i_clk, i_rst_n,
        cmd_pop && cmd_out[CMD_W-1], !cmd_pop,
        "back end took a command right after a frame close")

endmodule

`default_nettype wire
